// ===== hw/rtl/chained_free_block_allocator_core_assert.svh =====
// ----------------------------------------------------------------------------
// Chained free-block allocator assertion macros
// Shared property forms; each expects clk and rst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef CHAINED_FREE_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define CHAINED_FREE_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define CFBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CFBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cfba_pkg.sv =====
// ----------------------------------------------------------------------------
// cfba_pkg
// Types and constants shared by the allocator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfba_pkg;

  localparam int ID_W     = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADID   = 2'd2;

  typedef logic [3:0] dp_op_t;

  // Datapath operations issued by the controller
  localparam dp_op_t OP_NONE       = 4'd0;
  localparam dp_op_t OP_LATCH      = 4'd1;
  localparam dp_op_t OP_POP_RD     = 4'd2;
  localparam dp_op_t OP_POP_FIN    = 4'd3;
  localparam dp_op_t OP_PUSH       = 4'd4;
  localparam dp_op_t OP_CIN_START  = 4'd5;
  localparam dp_op_t OP_COUT_START = 4'd6;
  localparam dp_op_t OP_COPY       = 4'd7;
  localparam dp_op_t OP_CIN_FIN    = 4'd8;
  localparam dp_op_t OP_COUT_FIN   = 4'd9;
  localparam dp_op_t OP_NOSPACE    = 4'd10;
  localparam dp_op_t OP_BADID      = 4'd11;

  typedef struct packed {
    dp_op_t op;
    logic   copy_last;
  } dp_ctl_t;

  typedef struct packed {
    logic cmd_free;
    logic cnt_zero;
    logic cnt_full;
    logic link_zero;
    logic id_bad;
    logic idx_last;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cfba_ctrl.sv =====
// ----------------------------------------------------------------------------
// cfba_ctrl
// Sequencer for allocate/free: decides the path and steps list copies.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire cfba_pkg::dp_sts_t sts,
  output cfba_pkg::dp_ctl_t      ctl
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECIDE   = 3'd1;
  localparam logic [2:0] S_POP      = 3'd2;
  localparam logic [2:0] S_CIN      = 3'd3;
  localparam logic [2:0] S_COUT     = 3'd4;
  localparam logic [2:0] S_CIN_FIN  = 3'd5;
  localparam logic [2:0] S_COUT_FIN = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt     = state_r;
    ctl.op        = cfba_pkg::OP_NONE;
    ctl.copy_last = sts.idx_last;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.op    = cfba_pkg::OP_LATCH;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!sts.cmd_free) begin
          if (!sts.cnt_zero) begin
            ctl.op    = cfba_pkg::OP_POP_RD;
            state_nxt = S_POP;
          end else if (sts.link_zero) begin
            ctl.op    = cfba_pkg::OP_NOSPACE;
            state_nxt = S_IDLE;
          end else begin
            // follow the link: pull the saved list into the head
            ctl.op    = cfba_pkg::OP_CIN_START;
            state_nxt = S_CIN;
          end
        end else if (sts.id_bad) begin
          ctl.op    = cfba_pkg::OP_BADID;
          state_nxt = S_IDLE;
        end else if (!sts.cnt_full) begin
          ctl.op    = cfba_pkg::OP_PUSH;
          state_nxt = S_IDLE;
        end else begin
          // head full: spill it under the freed id
          ctl.op    = cfba_pkg::OP_COUT_START;
          state_nxt = S_COUT;
        end
      end
      S_POP: begin
        ctl.op    = cfba_pkg::OP_POP_FIN;
        state_nxt = S_IDLE;
      end
      S_CIN: begin
        ctl.op = cfba_pkg::OP_COPY;
        if (sts.idx_last) state_nxt = S_CIN_FIN;
      end
      S_COUT: begin
        ctl.op = cfba_pkg::OP_COPY;
        if (sts.idx_last) state_nxt = S_COUT_FIN;
      end
      S_CIN_FIN: begin
        ctl.op    = cfba_pkg::OP_CIN_FIN;
        state_nxt = S_IDLE;
      end
      S_COUT_FIN: begin
        ctl.op    = cfba_pkg::OP_COUT_FIN;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/cfba_dp.sv =====
// ----------------------------------------------------------------------------
// cfba_dp
// Head list RAM, chain store RAM, list counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cfba_dp #(
  parameter int LIST_LEN    = 16,
  parameter int BLOCK_LIMIT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cfba_pkg::dp_ctl_t                 ctl,
  output cfba_pkg::dp_sts_t                      sts,
  input  wire logic                              in_cmd,
  input  wire logic [cfba_pkg::ID_W-1:0]         in_free_id,
  output logic                                   out_strobe,
  output logic [cfba_pkg::ID_W-1:0]              out_alloc_id,
  output logic [cfba_pkg::STATUS_W-1:0]          out_status,
  output logic [cfba_pkg::COUNT_W-1:0]           out_free_count
);

  localparam int SW         = $clog2(LIST_LEN);
  localparam int IdW        = cfba_pkg::ID_W;
  localparam int CntW       = cfba_pkg::COUNT_W;
  localparam int ChainDepth = 1 << (IdW + SW);
  localparam logic [SW-1:0]   LastIdx  = SW'(LIST_LEN - 1);
  localparam logic [CntW-1:0] CountCap = CntW'((BLOCK_LIMIT < 511) ? BLOCK_LIMIT : 511);

  logic [IdW-1:0] head_mem  [LIST_LEN];
  logic [IdW-1:0] chain_mem [ChainDepth];

  logic            cmd_r;
  logic [IdW-1:0]  id_r;
  logic [IdW-1:0]  base_r;
  logic            dir_in_r;
  logic [SW-1:0]   cnt_r;
  logic [SW-1:0]   cnt_nxt;
  logic [IdW-1:0]  link_r;
  logic [IdW-1:0]  link_nxt;
  logic [CntW-1:0] fc_r;
  logic [CntW-1:0] fc_nxt;
  logic [SW-1:0]   idx_r;
  logic [SW-1:0]   idx_d_r;
  logic            pend_r;
  logic [IdW-1:0]  head_rd_r;
  logic [IdW-1:0]  chain_rd_r;

  logic            head_we;
  logic [SW-1:0]   head_wa;
  logic [SW-1:0]   head_ra;
  logic [IdW-1:0]  head_wd;
  logic            chain_we;
  logic [IdW-1:0]  chain_wd;
  logic            is_push;
  logic            is_dec;
  logic            is_inc;
  logic            is_res;

  assign is_push = (ctl.op == cfba_pkg::OP_PUSH);
  assign is_dec  = (ctl.op == cfba_pkg::OP_POP_FIN) || (ctl.op == cfba_pkg::OP_CIN_FIN);
  assign is_inc  = is_push || (ctl.op == cfba_pkg::OP_COUT_FIN);
  assign is_res  = is_dec || is_inc || (ctl.op == cfba_pkg::OP_NOSPACE) ||
                   (ctl.op == cfba_pkg::OP_BADID);

  // Status toward the controller
  assign sts.cmd_free  = cmd_r;
  assign sts.cnt_zero  = (cnt_r == '0);
  assign sts.cnt_full  = (cnt_r == LastIdx);
  assign sts.link_zero = (link_r == '0);
  assign sts.id_bad    = (id_r == '0) || (32'(id_r) >= BLOCK_LIMIT);
  assign sts.idx_last  = (idx_r == LastIdx);

  // Head RAM port: slot 0 is unused, the link lives in link_r
  assign head_ra = (ctl.op == cfba_pkg::OP_POP_RD) ? cnt_r : idx_r;
  assign head_we = is_push || (pend_r && dir_in_r && (idx_d_r != '0));
  assign head_wa = is_push ? (cnt_r + SW'(1)) : idx_d_r;
  assign head_wd = is_push ? id_r : chain_rd_r;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  // Chain RAM: one list per id, entry 0 holds the saved link
  assign chain_we = pend_r && !dir_in_r;
  assign chain_wd = (idx_d_r == '0) ? link_r : head_rd_r;

  always_ff @(posedge clk) begin
    if (chain_we) chain_mem[{base_r, idx_d_r}] <= chain_wd;
    chain_rd_r <= chain_mem[{base_r, idx_r}];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    case (ctl.op)
      cfba_pkg::OP_POP_FIN:  cnt_nxt = cnt_r - SW'(1);
      cfba_pkg::OP_PUSH:     cnt_nxt = cnt_r + SW'(1);
      cfba_pkg::OP_CIN_FIN:  cnt_nxt = LastIdx;
      cfba_pkg::OP_COUT_FIN: cnt_nxt = '0;
      default:               cnt_nxt = cnt_r;
    endcase
  end

  always_comb begin
    link_nxt = link_r;
    if (ctl.op == cfba_pkg::OP_COUT_FIN) begin
      link_nxt = base_r;
    end else if (pend_r && dir_in_r && (idx_d_r == '0)) begin
      link_nxt = chain_rd_r;
    end
  end

  always_comb begin
    fc_nxt = fc_r;
    if (is_dec && (fc_r != '0)) begin
      fc_nxt = fc_r - CntW'(1);
    end else if (is_inc && (fc_r < CountCap)) begin
      fc_nxt = fc_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      link_r     <= '0;
      fc_r       <= '0;
      pend_r     <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      link_r     <= link_nxt;
      fc_r       <= fc_nxt;
      pend_r     <= (ctl.op == cfba_pkg::OP_COPY);
      out_strobe <= is_res;
    end
  end

  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
    if (ctl.op == cfba_pkg::OP_LATCH) begin
      cmd_r <= in_cmd;
      id_r  <= in_free_id;
    end
    if (ctl.op == cfba_pkg::OP_CIN_START) begin
      base_r   <= link_r;
      dir_in_r <= 1'b1;
      idx_r    <= '0;
    end else if (ctl.op == cfba_pkg::OP_COUT_START) begin
      base_r   <= id_r;
      dir_in_r <= 1'b0;
      idx_r    <= '0;
    end else if ((ctl.op == cfba_pkg::OP_COPY) && !ctl.copy_last) begin
      idx_r <= idx_r + SW'(1);
    end
    if (is_res) begin
      out_free_count <= fc_nxt;
      case (ctl.op)
        cfba_pkg::OP_POP_FIN: out_alloc_id <= head_rd_r;
        cfba_pkg::OP_CIN_FIN: out_alloc_id <= base_r;
        default:              out_alloc_id <= '0;
      endcase
      case (ctl.op)
        cfba_pkg::OP_NOSPACE: out_status <= cfba_pkg::ST_NOSPACE;
        cfba_pkg::OP_BADID:   out_status <= cfba_pkg::ST_BADID;
        default:              out_status <= cfba_pkg::ST_OK;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chained_free_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// chained_free_block_allocator_core
// Block-number allocator over a chained free list held in two RAMs.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                         | Handshake
//  ---------+-----------------------------------------------+-------------------
//  input    | in_cmd, in_free_id                            | start & !busy
//  result   | out_alloc_id, out_status, out_free_count      | out_strobe, 1 cycle
//
//  Accept to strobe: the item is latched and decided; a pop then reads the head
//  list, while a push, no-space or bad-id result comes from the decision itself.
//  A whole list moves through the head and chain RAM ports, one entry per cycle.
//  busy drops in the strobe cycle, so the next item may start there.
//  Reset clears counters and link; RAM contents need no clearing.
//  Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_free_block_allocator_core #(
  parameter int LIST_LEN    = 16,
  parameter int BLOCK_LIMIT = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_cmd,
  input  wire logic [cfba_pkg::ID_W-1:0]         in_free_id,
  output logic                                   out_strobe,
  output logic [cfba_pkg::ID_W-1:0]              out_alloc_id,
  output logic [cfba_pkg::STATUS_W-1:0]          out_status,
  output logic [cfba_pkg::COUNT_W-1:0]           out_free_count
);

  cfba_pkg::dp_ctl_t ctl;
  cfba_pkg::dp_sts_t sts;
  logic              res_fail;

  cfba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  cfba_dp #(
    .LIST_LEN    (LIST_LEN),
    .BLOCK_LIMIT (BLOCK_LIMIT)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_cmd         (in_cmd),
    .in_free_id     (in_free_id),
    .out_strobe     (out_strobe),
    .out_alloc_id   (out_alloc_id),
    .out_status     (out_status),
    .out_free_count (out_free_count)
  );

  assign res_fail = out_strobe && (out_status != cfba_pkg::ST_OK);

`include "chained_free_block_allocator_core_assert.svh"

  `CFBA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "item accepted but core not busy")
  `CFBA_ASSERT_IMP(a_strobe_idle, out_strobe, !busy, "result strobe while still busy")
  `CFBA_ASSERT_IMP(a_fail_zero_id, res_fail, out_alloc_id == '0, "failed result carries an id")

endmodule

`default_nettype wire
